// ===== design/trs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trs_pkg: shared types and constants for threshold region steering
// Pixel and result payloads, counter widths, steering codes and commands.
// ---------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int X3_W      = COL_W + 2;
  localparam int FW_W      = 11;
  localparam int CNT_W     = 19;
  localparam int CMD_W     = 11;
  localparam int ADDR_W    = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [FW_W-1:0]  FW_MIN  = FW_W'(3);
  localparam logic [FW_W-1:0]  FW_MAX  = FW_W'(MAX_WIDTH);

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH = 2'd1;
  localparam logic [1:0] REG_LOITER      = 2'd2;

  localparam logic [7:0]      THRESHOLD_RST   = 8'd128;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST = FW_W'(640);

  typedef enum logic [2:0] {
    DIR_STOP     = 3'd0,
    DIR_LEFT     = 3'd1,
    DIR_FORWARD  = 3'd2,
    DIR_RIGHT    = 3'd3,
    DIR_STRAIGHT = 3'd4
  } trs_dir_t;

  // command = base - 0.6 * action; all values already sit inside 1100..1900
  localparam int RC_BASE = 1500;
  localparam logic [CMD_W-1:0] RC_NEUTRAL     = CMD_W'(RC_BASE);
  localparam logic [CMD_W-1:0] RC_ACT_POS100  = CMD_W'(RC_BASE - (100 * 6) / 10);
  localparam logic [CMD_W-1:0] RC_ACT_NEG100  = CMD_W'(RC_BASE + (100 * 6) / 10);
  localparam logic [CMD_W-1:0] RC_ACT_POS200  = CMD_W'(RC_BASE - (200 * 6) / 10);

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_in_frame;
  } trs_in_t;

  typedef struct packed {
    logic [2:0]       direction;
    logic [CMD_W-1:0] roll_command;
    logic [CMD_W-1:0] pitch_command;
    logic [CNT_W-1:0] black_left;
    logic [CNT_W-1:0] black_middle;
    logic [CNT_W-1:0] black_right;
  } trs_out_t;

  // frame counts handed from the accumulator to the decision stage
  typedef struct packed {
    logic [2:0][CNT_W-1:0] blk;
    logic [2:0][CNT_W-1:0] tot;
  } trs_snap_t;

  typedef struct packed {
    logic [7:0]      threshold;
    logic [FW_W-1:0] frame_width;
    logic            loiter_mode;
  } trs_cfg_t;

  function automatic logic [CMD_W-1:0] roll_cmd(input trs_dir_t dir, input logic loiter);
    logic [CMD_W-1:0] v;
    v = RC_NEUTRAL;
    if (loiter) begin
      case (dir)
        DIR_LEFT:  v = RC_ACT_POS100;
        DIR_RIGHT: v = RC_ACT_NEG100;
        default:   v = RC_NEUTRAL;
      endcase
    end
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] pitch_cmd(input trs_dir_t dir, input logic loiter);
    logic [CMD_W-1:0] v;
    v = RC_NEUTRAL;
    if (loiter) begin
      case (dir)
        DIR_LEFT, DIR_RIGHT, DIR_STRAIGHT: v = RC_ACT_POS100;
        DIR_FORWARD:                       v = RC_ACT_POS200;
        default:                           v = RC_NEUTRAL;
      endcase
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/trs_cfg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trs_cfg: configuration register file
// APB-style access to threshold, frame width and loiter mode.
// ---------------------------------------------------------------------------
`default_nettype none

module trs_cfg import trs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output trs_cfg_t               cfg
);

  trs_cfg_t   cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_THRESHOLD:   cfg_nxt.threshold   = pwdata[7:0];
        REG_FRAME_WIDTH: cfg_nxt.frame_width = pwdata[FW_W-1:0];
        REG_LOITER:      cfg_nxt.loiter_mode = pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD:   prdata = {24'd0, cfg_r.threshold};
      REG_FRAME_WIDTH: prdata = {{(32-FW_W){1'b0}}, cfg_r.frame_width};
      REG_LOITER:      prdata = {31'd0, cfg_r.loiter_mode};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold   <= THRESHOLD_RST;
      cfg_r.frame_width <= FRAME_WIDTH_RST;
      cfg_r.loiter_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/trs_accum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trs_accum: per-pixel region counting
// Column tracking, saturating black/total counters per third, frame snapshot.
// ---------------------------------------------------------------------------
`default_nettype none

module trs_accum import trs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire trs_cfg_t  cfg,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire trs_in_t   in_data,
  input  wire logic      snap_take,
  output logic           snap_valid,
  output trs_snap_t      snap
);

  logic [COL_W-1:0]      col_r, col_nxt;
  logic [2:0][CNT_W-1:0] blk_r, blk_nxt, tot_r, tot_nxt;
  logic [2:0][CNT_W-1:0] blk_upd, tot_upd;
  logic                  snap_valid_r, snap_valid_nxt;
  trs_snap_t             snap_r, snap_nxt;
  logic [FW_W-1:0]       eff_w;
  logic [X3_W-1:0]       x3;
  logic [2:0]            region_hit;
  logic                  is_black;
  logic                  in_acc;
  logic [COL_W:0]        col_inc;

  // snapshot slot frees up when the decision stage takes it
  assign in_stall   = snap_valid_r && !snap_take;
  assign in_acc     = in_valid && !in_stall;
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  always_comb begin
    if (cfg.frame_width < FW_MIN)      eff_w = FW_MIN;
    else if (cfg.frame_width > FW_MAX) eff_w = FW_MAX;
    else                               eff_w = cfg.frame_width;
  end

  // thirds: left if 3x < W, middle if 3x < 2W
  assign x3 = X3_W'({col_r, 1'b0}) + X3_W'(col_r);

  always_comb begin
    region_hit = 3'b000;
    if (x3 < X3_W'(eff_w))             region_hit[0] = 1'b1;
    else if (x3 < X3_W'({eff_w, 1'b0})) region_hit[1] = 1'b1;
    else                               region_hit[2] = 1'b1;
  end

  assign is_black = in_data.pixel < cfg.threshold;
  assign col_inc  = {1'b0, col_r} + 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tot_upd[k] = tot_r[k];
      blk_upd[k] = blk_r[k];
      if (region_hit[k]) begin
        if (tot_r[k] != CNT_MAX) tot_upd[k] = tot_r[k] + 1'b1;
        if (is_black && blk_r[k] != CNT_MAX) blk_upd[k] = blk_r[k] + 1'b1;
      end
    end
  end

  always_comb begin
    col_nxt        = col_r;
    blk_nxt        = blk_r;
    tot_nxt        = tot_r;
    snap_nxt       = snap_r;
    snap_valid_nxt = snap_valid_r && !snap_take;
    if (in_acc) begin
      if (in_data.last_in_frame) begin
        col_nxt        = '0;
        blk_nxt        = '0;
        tot_nxt        = '0;
        snap_nxt.blk   = blk_upd;
        snap_nxt.tot   = tot_upd;
        snap_valid_nxt = 1'b1;
      end else begin
        blk_nxt = blk_upd;
        tot_nxt = tot_upd;
        if (FW_W'(col_inc) >= eff_w) col_nxt = '0;
        else                         col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      blk_r        <= '0;
      tot_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      blk_r        <= blk_nxt;
      tot_r        <= tot_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_in_frame |=> snap_valid_r && col_r == '0 && tot_r == '0)
    else $error("frame end did not clear counters or load snapshot");

  a_black_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    blk_r[0] <= tot_r[0] && blk_r[1] <= tot_r[1] && blk_r[2] <= tot_r[2])
    else $error("black count above region total");

  a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid_r && !snap_take |=> snap_valid_r && $stable(snap_r))
    else $error("pending snapshot lost or changed");

endmodule

`default_nettype wire

// ===== design/trs_decide.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trs_decide: steering decision and result register
// Eighty percent test per third, strict minimum search, command lookup.
// ---------------------------------------------------------------------------
`default_nettype none

module trs_decide import trs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      loiter_mode,
  input  wire logic      snap_valid,
  input  wire trs_snap_t snap,
  output logic           snap_take,
  output logic           out_valid,
  input  wire logic      out_stall,
  output trs_out_t       out_data
);

  logic       out_valid_r, out_valid_nxt;
  trs_out_t   out_r, out_nxt;
  logic [2:0] mostly_black;
  trs_dir_t   dir;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign snap_take = snap_valid && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // over 80 percent black: 5*black > 4*total
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mostly_black[k] = ({3'b000, snap.blk[k]} + {1'b0, snap.blk[k], 2'b00})
                        > {1'b0, snap.tot[k], 2'b00};
    end
  end

  always_comb begin
    if (&mostly_black)
      dir = DIR_STOP;
    else if (snap.blk[0] < snap.blk[1] && snap.blk[0] < snap.blk[2])
      dir = DIR_LEFT;
    else if (snap.blk[1] < snap.blk[0] && snap.blk[1] < snap.blk[2])
      dir = DIR_FORWARD;
    else if (snap.blk[2] < snap.blk[0] && snap.blk[2] < snap.blk[1])
      dir = DIR_RIGHT;
    else
      dir = DIR_STRAIGHT;
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (snap_take) begin
      out_nxt.direction     = dir;
      out_nxt.roll_command  = roll_cmd(dir, loiter_mode);
      out_nxt.pitch_command = pitch_cmd(dir, loiter_mode);
      out_nxt.black_left    = snap.blk[0];
      out_nxt.black_middle  = snap.blk[1];
      out_nxt.black_right   = snap.blk[2];
      out_valid_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  a_left_is_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.direction == DIR_LEFT |->
      out_r.black_left < out_r.black_middle && out_r.black_left < out_r.black_right)
    else $error("left steer without strict left minimum");

  a_right_is_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.direction == DIR_RIGHT |->
      out_r.black_right < out_r.black_left && out_r.black_right < out_r.black_middle)
    else $error("right steer without strict right minimum");

  a_stop_has_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.direction == DIR_STOP |->
      out_r.black_left != '0 && out_r.black_middle != '0 && out_r.black_right != '0)
    else $error("stop issued with an empty third");

endmodule

`default_nettype wire

// ===== design/threshold_region_steering_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// threshold_region_steering_top: pixel-stream region steering
// Counts black pixels per row third and emits one steering result per frame.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in_      | in_valid / in_stall    | trs_in_t  (pixel, last_in_frame)
//  out_     | out_valid / out_stall  | trs_out_t (direction, commands, counts)
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// One pixel request per cycle while in_stall is low; counters update at the accepting edge.
// A frame-end pixel loads a snapshot; the result register takes it when not held by out_stall.
// in_stall rises only while a snapshot waits and the result register is held.
// Synchronous active-low reset clears counters, column and both valid flags.
// ---------------------------------------------------------------------------
`default_nettype none

module threshold_region_steering_top import trs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire trs_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output trs_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  trs_cfg_t  cfg;
  trs_snap_t snap;
  logic      snap_valid;
  logic      snap_take;

  trs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trs_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  trs_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .loiter_mode (cfg.loiter_mode),
    .snap_valid  (snap_valid),
    .snap        (snap),
    .snap_take   (snap_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
